FILE: design/fire_ellipse_dimensions_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fire ellipse dimensions core
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FIRE_ELLIPSE_DIMENSIONS_CORE_DEFINES_SVH
`define FIRE_ELLIPSE_DIMENSIONS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg
// Types and constants shared by the fire ellipse dimensions datapath.
// ----------------------------------------------------------------------------
package fed_pkg;

  // pi in Q2.29 and Q2.30
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  typedef struct packed {
    logic [15:0] w;
    logic [19:0] rate;
    logic [15:0] t;
  } seg_a_t;

  typedef struct packed {
    logic [15:0] w;
    logic [19:0] rate;
    logic [15:0] t;
    logic [29:0] h30;
  } seg_b_t;

  typedef struct packed {
    logic [15:0] w;
    logic [19:0] rate;
    logic [15:0] t;
    logic [29:0] h30;
    logic [15:0] e16;
  } seg_c_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] t;
    logic [29:0] h30;
    logic [15:0] e16;
    logic [19:0] back;
  } mid_t;

  typedef struct packed {
    mid_t        mid;
    logic [36:0] st;
    logic [31:0] ct8;
  } seg_e_t;

  typedef struct packed {
    logic [14:0] lwr;
    logic [15:0] e16;
    logic [19:0] back;
    logic [31:0] at8;
    logic [31:0] bt8;
    logic [31:0] ct8;
    logic [32:0] len8;
    logic [32:0] wid8;
  } geom_t;

  typedef struct packed {
    geom_t       g;
    logic [30:0] s8;
    logic [29:0] h30;
    logic [59:0] hh;
    logic [59:0] m;
  } stage1_t;

  typedef struct packed {
    geom_t       g;
    logic [30:0] s8;
    logic [30:0] f30;
    logic [61:0] mhp;
    logic [61:0] mlp;
  } stage2_t;

  typedef struct packed {
    geom_t       g;
    logic [61:0] ps;
    logic [47:0] area;
  } stage3_t;

  typedef struct packed {
    logic [14:0] lwr;
    logic [15:0] ecc;
    logic [19:0] back;
    logic [31:0] semi_minor;
    logic [31:0] semi_major;
    logic [31:0] offset;
    logic [32:0] length;
    logic [32:0] width;
    logic [34:0] perim;
    logic [47:0] area;
  } res_t;

endpackage

FILE: design/fed_div.sv
// ----------------------------------------------------------------------------
// fed_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fed_div #(
  parameter int NUM_W  = 53,
  parameter int DEN_W  = 34,
  parameter int Q_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [Q_W-1:0]    v_r;
  logic [DEN_W-1:0]  rem_r   [Q_W];
  logic [DEN_W-1:0]  rem_nxt [Q_W];
  logic [DEN_W-1:0]  rem_src [Q_W];
  logic [Q_W-1:0]    nq_r    [Q_W];
  logic [Q_W-1:0]    nq_nxt  [Q_W];
  logic [Q_W-1:0]    nq_src  [Q_W];
  logic [DEN_W-1:0]  d_r     [Q_W];
  logic [DEN_W-1:0]  d_src   [Q_W];
  logic [SIDE_W-1:0] side_r  [Q_W];

  always_comb begin
    logic [DEN_W:0] trial;
    rem_src[0] = DEN_W'(num_i >> Q_W);
    nq_src[0]  = num_i[Q_W-1:0];
    d_src[0]   = den_i;
    for (int k = 1; k < Q_W; k++) begin
      rem_src[k] = rem_r[k-1];
      nq_src[k]  = nq_r[k-1];
      d_src[k]   = d_r[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      // bring down the next numerator bit, subtract if it fits
      trial = {rem_src[k], nq_src[k][Q_W-1]};
      if (trial >= {1'b0, d_src[k]}) begin
        rem_nxt[k] = DEN_W'(trial - {1'b0, d_src[k]});
        nq_nxt[k]  = Q_W'({nq_src[k], 1'b1});
      end else begin
        rem_nxt[k] = DEN_W'(trial);
        nq_nxt[k]  = Q_W'({nq_src[k], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= Q_W'({v_r, valid_i});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
        d_r[k]   <= d_src[k];
      end
      for (int k = 1; k < Q_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_o = v_r[Q_W-1];
  assign quot_o  = nq_r[Q_W-1];
  assign rem_o   = rem_r[Q_W-1];
  assign side_o  = side_r[Q_W-1];

endmodule

FILE: design/fed_sqrt.sv
// ----------------------------------------------------------------------------
// fed_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fed_sqrt #(
  parameter int IN_W   = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   val_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = IN_W / 2;

  logic [RW-1:0]     v_r;
  logic [RW+1:0]     rem_r    [RW];
  logic [RW+1:0]     rem_nxt  [RW];
  logic [RW+1:0]     rem_src  [RW];
  logic [RW-1:0]     root_r   [RW];
  logic [RW-1:0]     root_nxt [RW];
  logic [RW-1:0]     root_src [RW];
  logic [IN_W-1:0]   val_r    [RW];
  logic [IN_W-1:0]   val_src  [RW];
  logic [SIDE_W-1:0] side_r   [RW];

  always_comb begin
    logic [RW+3:0] shifted;
    logic [RW+1:0] trial;
    rem_src[0]  = '0;
    root_src[0] = '0;
    val_src[0]  = val_i;
    for (int k = 1; k < RW; k++) begin
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
      val_src[k]  = val_r[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      // bring down two radicand bits, try root*4+1
      shifted = {rem_src[k], val_src[k][IN_W-1 -: 2]};
      trial   = {root_src[k], 2'b01};
      if (shifted >= {2'b00, trial}) begin
        rem_nxt[k]  = (RW+2)'(shifted - {2'b00, trial});
        root_nxt[k] = RW'({root_src[k], 1'b1});
      end else begin
        rem_nxt[k]  = (RW+2)'(shifted);
        root_nxt[k] = RW'({root_src[k], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= RW'({v_r, valid_i});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < RW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        val_r[k]  <= IN_W'({val_src[k], 2'b00});
      end
      for (int k = 1; k < RW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_o = v_r[RW-1];
  assign root_o  = root_r[RW-1];
  assign side_o  = side_r[RW-1];

endmodule

FILE: design/fed_skid.sv
// ----------------------------------------------------------------------------
// fed_skid
// Two-entry result buffer between the datapath and the result channel.
// ----------------------------------------------------------------------------
module fed_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  fed_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output fed_pkg::res_t data_o
);

  fed_pkg::res_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          pop;

  assign valid_o = (cnt_r != 2'd0);
  assign full_o  = (cnt_r == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push_i, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) wr_ptr_r <= !wr_ptr_r;
      if (pop)    rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

FILE: design/fire_ellipse_dimensions_core.sv
// ----------------------------------------------------------------------------
// fire_ellipse_dimensions_core
// Elliptical fire shape from wind, head spread rate and elapsed time.
// ----------------------------------------------------------------------------
// A fully pipelined datapath that takes one transfer of wind speed, head
// rate and elapsed time every clock while in_stall is low, and returns one
// transfer of ten shape results per input, in order. Throughput is one item
// per cycle while the pipe is not halted; the depth is set by the chain of
// bit-per-stage units: the 33-stage reciprocal divider for the ratio squared,
// the 16-stage square root for the eccentricity, the 20-stage backing-rate
// divider and the 31-stage dividers for the minor axis and the perimeter sum,
// plus eleven register stages around them. A two-entry buffer sits at the
// result port, so the pipe keeps moving while one result waits; in_stall
// rises only when both entries hold results. No state survives between items
// and reset only clears the valid bits and the buffer's count and pointers.
// ----------------------------------------------------------------------------
`include "fire_ellipse_dimensions_core_defines.svh"

module fire_ellipse_dimensions_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_wind_speed,
  input  logic [19:0] in_head_rate,
  input  logic [15:0] in_elapsed_minutes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_length_width_ratio,
  output logic [15:0] out_eccentricity,
  output logic [19:0] out_back_rate,
  output logic [31:0] out_semi_minor,
  output logic [31:0] out_semi_major,
  output logic [31:0] out_centre_offset,
  output logic [32:0] out_fire_length,
  output logic [32:0] out_max_width,
  output logic [34:0] out_perimeter,
  output logic [47:0] out_area
);

  // Whole pipe advances together; it halts only when the result buffer is full.
  logic pipe_en;
  logic skid_full;
  assign pipe_en  = !skid_full;
  assign in_stall = skid_full;

  // ---- S0: register the transfer, form r10^2, den^2 and wind^2 ----
  logic             s0_v_r;
  fed_pkg::seg_a_t  s0_side_r, s0_side_nxt;
  logic [33:0]      s0_d_r, s0_d_nxt;
  logic [33:0]      s0_dd_r, s0_dd_nxt;
  logic [31:0]      s0_ww_r, s0_ww_nxt;

  always_comb begin
    logic [16:0] r10;
    logic [16:0] den;
    r10 = {1'b0, in_wind_speed} + 17'd1024;
    den = {1'b0, in_wind_speed} + 17'd2048;
    s0_side_nxt.w    = in_wind_speed;
    s0_side_nxt.rate = in_head_rate;
    s0_side_nxt.t    = in_elapsed_minutes;
    s0_d_nxt         = r10 * r10;
    s0_dd_nxt        = den * den;
    s0_ww_nxt        = in_wind_speed * in_wind_speed;
  end

  // ---- 2^52 / r10^2 with remainder, and h30 = wind^2 * 2^30 / den^2, side by side ----
  logic            d1_v;
  logic [32:0]     d1_q;
  logic [33:0]     d1_rem;
  fed_pkg::seg_a_t d1_side;
  logic [32:0]     d5_q;

  fed_div #(
    .NUM_W (53),
    .DEN_W (34),
    .Q_W   (33),
    .SIDE_W($bits(fed_pkg::seg_a_t))
  ) u_div_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s0_v_r),
    .num_i  ({1'b1, 52'd0}),
    .den_i  (s0_d_r),
    .side_i (s0_side_r),
    .valid_o(d1_v),
    .quot_o (d1_q),
    .rem_o  (d1_rem),
    .side_o (d1_side)
  );

  fed_div #(
    .NUM_W (62),
    .DEN_W (34),
    .Q_W   (33),
    .SIDE_W(1)
  ) u_div_shape (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s0_v_r),
    .num_i  ({s0_ww_r, 30'd0}),
    .den_i  (s0_dd_r),
    .side_i (1'b0),
    .valid_o(),
    .quot_o (d5_q),
    .rem_o  (),
    .side_o ()
  );

  // ---- S1: e^2 in Q.32 = 2^32 - ceil(2^52 / r10^2) ----
  logic            s1_v_r;
  logic [31:0]     s1_q_r, s1_q_nxt;
  fed_pkg::seg_b_t s1_side_r, s1_side_nxt;

  always_comb begin
    logic [33:0] ceil_q;
    logic [33:0] diff;
    ceil_q = {1'b0, d1_q} + {33'd0, (d1_rem != 34'd0)};
    diff   = 34'h1_0000_0000 - ceil_q;
    s1_q_nxt         = diff[31:0];
    s1_side_nxt.w    = d1_side.w;
    s1_side_nxt.rate = d1_side.rate;
    s1_side_nxt.t    = d1_side.t;
    s1_side_nxt.h30  = d5_q[29:0];
  end

  // ---- eccentricity in Q0.16 ----
  logic            sq_v;
  logic [15:0]     sq_root;
  fed_pkg::seg_b_t sq_side;

  fed_sqrt #(
    .IN_W  (32),
    .SIDE_W($bits(fed_pkg::seg_b_t))
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s1_v_r),
    .val_i  (s1_q_r),
    .side_i (s1_side_r),
    .valid_o(sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // ---- S2: backing rate operands R*(1-e) and (1+e) ----
  logic            s2_v_r;
  logic [36:0]     s2_num_r, s2_num_nxt;
  logic [16:0]     s2_den_r, s2_den_nxt;
  fed_pkg::seg_c_t s2_side_r, s2_side_nxt;

  always_comb begin
    logic [16:0] one_minus;
    one_minus        = 17'h10000 - {1'b0, sq_root};
    s2_num_nxt       = sq_side.rate * one_minus;
    s2_den_nxt       = 17'h10000 + {1'b0, sq_root};
    s2_side_nxt.w    = sq_side.w;
    s2_side_nxt.rate = sq_side.rate;
    s2_side_nxt.t    = sq_side.t;
    s2_side_nxt.h30  = sq_side.h30;
    s2_side_nxt.e16  = sq_root;
  end

  logic            d2_v;
  logic [19:0]     d2_q;
  fed_pkg::seg_c_t d2_side;

  fed_div #(
    .NUM_W (37),
    .DEN_W (17),
    .Q_W   (20),
    .SIDE_W($bits(fed_pkg::seg_c_t))
  ) u_div_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s2_v_r),
    .num_i  (s2_num_r),
    .den_i  (s2_den_r),
    .side_i (s2_side_r),
    .valid_o(d2_v),
    .quot_o (d2_q),
    .rem_o  (),
    .side_o (d2_side)
  );

  // ---- S3: head plus and minus back ----
  logic          s3_v_r;
  fed_pkg::mid_t s3_mid_r, s3_mid_nxt;
  logic [20:0]   s3_sum_r, s3_sum_nxt;
  logic [19:0]   s3_dif_r, s3_dif_nxt;

  always_comb begin
    s3_mid_nxt.w    = d2_side.w;
    s3_mid_nxt.t    = d2_side.t;
    s3_mid_nxt.h30  = d2_side.h30;
    s3_mid_nxt.e16  = d2_side.e16;
    s3_mid_nxt.back = d2_q;
    s3_sum_nxt      = {1'b0, d2_side.rate} + {1'b0, d2_q};
    s3_dif_nxt      = d2_side.rate - d2_q;
  end

  // ---- S4: scale by time ----
  logic          s4_v_r;
  fed_pkg::mid_t s4_mid_r;
  logic [36:0]   s4_st_r, s4_st_nxt;
  logic [35:0]   s4_dt_r, s4_dt_nxt;

  assign s4_st_nxt = s3_sum_r * s3_mid_r.t;
  assign s4_dt_nxt = s3_dif_r * s3_mid_r.t;

  // ---- S5: partial products of st * den ----
  logic          s5_v_r;
  fed_pkg::mid_t s5_mid_r;
  logic [36:0]   s5_st_r;
  logic [31:0]   s5_ct8_r, s5_ct8_nxt;
  logic [37:0]   s5_phi_r, s5_phi_nxt;
  logic [32:0]   s5_plo_r, s5_plo_nxt;

  always_comb begin
    logic [16:0] den;
    den        = {1'b0, s4_mid_r.w} + 17'd2048;
    s5_ct8_nxt = {3'd0, s4_dt_r[35:7]};
    s5_phi_nxt = s4_st_r[36:16] * den;
    s5_plo_nxt = s4_st_r[15:0] * den;
  end

  // ---- S6: sum the partial products ----
  logic            s6_v_r;
  fed_pkg::seg_e_t s6_side_r, s6_side_nxt;
  logic [53:0]     s6_sd_r, s6_sd_nxt;

  always_comb begin
    s6_side_nxt.mid = s5_mid_r;
    s6_side_nxt.st  = s5_st_r;
    s6_side_nxt.ct8 = s5_ct8_r;
    s6_sd_nxt       = {s5_phi_r, 16'd0} + {21'd0, s5_plo_r};
  end

  // ---- st*16 / r10 gives the width and the minor axis; st*den / (r10*128) is a+b ----
  logic [16:0] s6_r10;
  assign s6_r10 = {1'b0, s6_side_r.mid.w} + 17'd1024;

  logic            d3_v;
  logic [30:0]     d3_q;
  logic [30:0]     d4_q;
  fed_pkg::seg_e_t d4_side;

  fed_div #(
    .NUM_W (41),
    .DEN_W (17),
    .Q_W   (31),
    .SIDE_W(1)
  ) u_div_width (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s6_v_r),
    .num_i  ({s6_side_r.st, 4'd0}),
    .den_i  (s6_r10),
    .side_i (1'b0),
    .valid_o(d3_v),
    .quot_o (d3_q),
    .rem_o  (),
    .side_o ()
  );

  fed_div #(
    .NUM_W (54),
    .DEN_W (24),
    .Q_W   (31),
    .SIDE_W($bits(fed_pkg::seg_e_t))
  ) u_div_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .valid_i(s6_v_r),
    .num_i  (s6_sd_r),
    .den_i  ({s6_r10, 7'd0}),
    .side_i (s6_side_r),
    .valid_o(),
    .quot_o (d4_q),
    .rem_o  (),
    .side_o (d4_side)
  );

  // ---- P1: geometry fields, h^2 and A*B ----
  logic             p1_v_r;
  fed_pkg::stage1_t p1_r, p1_nxt;

  always_comb begin
    logic [16:0] r10;
    r10              = {1'b0, d4_side.mid.w} + 17'd1024;
    p1_nxt.g.lwr     = r10[16:2];
    p1_nxt.g.e16     = d4_side.mid.e16;
    p1_nxt.g.back    = d4_side.mid.back;
    p1_nxt.g.at8     = {2'd0, d3_q[30:1]};
    p1_nxt.g.bt8     = {2'd0, d4_side.st[36:7]};
    p1_nxt.g.ct8     = d4_side.ct8;
    p1_nxt.g.len8    = {2'd0, d4_side.st[36:6]};
    p1_nxt.g.wid8    = {2'd0, d3_q};
    p1_nxt.s8        = d4_q;
    p1_nxt.h30       = d4_side.mid.h30;
    p1_nxt.hh        = d4_side.mid.h30 * d4_side.mid.h30;
    p1_nxt.m         = d3_q[30:1] * d4_side.st[36:7];
  end

  // ---- P2: series factor and the two halves of pi*A*B ----
  logic             p2_v_r;
  fed_pkg::stage2_t p2_r, p2_nxt;

  always_comb begin
    p2_nxt.g   = p1_r.g;
    p2_nxt.s8  = p1_r.s8;
    p2_nxt.f30 = 31'h4000_0000 + {3'd0, p1_r.h30[29:2]} + {7'd0, p1_r.hh[59:36]};
    p2_nxt.mhp = p1_r.m[59:30] * fed_pkg::PI_Q30;
    p2_nxt.mlp = p1_r.m[29:0] * fed_pkg::PI_Q30;
  end

  // ---- P3: (a+b) * series factor, combine the area halves ----
  logic             p3_v_r;
  fed_pkg::stage3_t p3_r, p3_nxt;

  always_comb begin
    logic [62:0] asum;
    asum        = {1'b0, p2_r.mhp} + {31'd0, p2_r.mlp[61:30]};
    p3_nxt.g    = p2_r.g;
    p3_nxt.ps   = p2_r.s8 * p2_r.f30;
    p3_nxt.area = {1'b0, asum[62:16]};
  end

  // ---- P4: times pi, pack the result ----
  logic          p4_v_r;
  fed_pkg::res_t p4_r, p4_nxt;

  always_comb begin
    logic [62:0] pp;
    pp                = p3_r.ps[61:30] * fed_pkg::PI_Q29;
    p4_nxt.lwr        = p3_r.g.lwr;
    p4_nxt.ecc        = p3_r.g.e16;
    p4_nxt.back       = p3_r.g.back;
    p4_nxt.semi_minor = p3_r.g.at8;
    p4_nxt.semi_major = p3_r.g.bt8;
    p4_nxt.offset     = p3_r.g.ct8;
    p4_nxt.length     = p3_r.g.len8;
    p4_nxt.width      = p3_r.g.wid8;
    p4_nxt.perim      = {1'b0, pp[62:29]};
    p4_nxt.area       = p3_r.area;
  end

  // ---- stage registers: valid bits reset, payload just advances ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (pipe_en) begin
      s0_v_r <= in_valid;
      s1_v_r <= d1_v;
      s2_v_r <= sq_v;
      s3_v_r <= d2_v;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      p1_v_r <= d3_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_side_r <= s0_side_nxt;
      s0_d_r    <= s0_d_nxt;
      s0_dd_r   <= s0_dd_nxt;
      s0_ww_r   <= s0_ww_nxt;
      s1_q_r    <= s1_q_nxt;
      s1_side_r <= s1_side_nxt;
      s2_num_r  <= s2_num_nxt;
      s2_den_r  <= s2_den_nxt;
      s2_side_r <= s2_side_nxt;
      s3_mid_r  <= s3_mid_nxt;
      s3_sum_r  <= s3_sum_nxt;
      s3_dif_r  <= s3_dif_nxt;
      s4_mid_r  <= s3_mid_r;
      s4_st_r   <= s4_st_nxt;
      s4_dt_r   <= s4_dt_nxt;
      s5_mid_r  <= s4_mid_r;
      s5_st_r   <= s4_st_r;
      s5_ct8_r  <= s5_ct8_nxt;
      s5_phi_r  <= s5_phi_nxt;
      s5_plo_r  <= s5_plo_nxt;
      s6_side_r <= s6_side_nxt;
      s6_sd_r   <= s6_sd_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      p4_r      <= p4_nxt;
    end
  end

  // ---- result buffer ----
  fed_pkg::res_t out_data;

  fed_skid u_skid (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (pipe_en && p4_v_r),
    .data_i (p4_r),
    .full_o (skid_full),
    .valid_o(out_valid),
    .stall_i(out_stall),
    .data_o (out_data)
  );

  assign out_length_width_ratio = out_data.lwr;
  assign out_eccentricity       = out_data.ecc;
  assign out_back_rate          = out_data.back;
  assign out_semi_minor         = out_data.semi_minor;
  assign out_semi_major         = out_data.semi_major;
  assign out_centre_offset      = out_data.offset;
  assign out_fire_length        = out_data.length;
  assign out_max_width          = out_data.width;
  assign out_perimeter          = out_data.perim;
  assign out_area               = out_data.area;

  // ---- checks ----
  // Halt only with a result on offer.
  `FED_ASSERT_NOW(a_halt_has_result, !pipe_en, out_valid, "pipe halted with no result offered")
  // Hold the last stage while halted.
  `FED_ASSERT_NEXT(a_halt_holds_tail, !pipe_en && p4_v_r, p4_v_r && $stable(p4_r),
    "last stage changed while halted")
  // Width and minor axis come from one quotient.
  `FED_ASSERT_NOW(a_width_minor, out_valid, out_max_width[32:1] == out_semi_minor,
    "max width and semi-minor axis disagree")
  // Length and major axis come from one product.
  `FED_ASSERT_NOW(a_length_major, out_valid, out_fire_length[32:1] == out_semi_major,
    "fire length and semi-major axis disagree")

endmodule
